>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Field widths, codes and default sizing shared by the allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Default tree sizing
    localparam int NUM_LEVELS_DEF    = 12;
    localparam int MIN_BLOCK_LOG_DEF = 5;

    // Field widths of the request and response beats
    localparam int OP_W      = 1;
    localparam int REQ_W     = 17;
    localparam int OFFSET_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int BYTES_W   = 17;
    localparam int HDR_W     = 8;

    // Header register reset value
    localparam logic [HDR_W-1:0] HEADER_RESET = 8'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

endpackage

>>> hw/rtl/bba_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::OP_W-1:0]    op;
    logic [bba_pkg::REQ_W-1:0]   request_bytes;
    logic [bba_pkg::OFFSET_W-1:0] free_offset;

    modport source (output valid, output op, output request_bytes,
                    output free_offset, input ready);
    modport sink   (input valid, input op, input request_bytes,
                    input free_offset, output ready);
endinterface

>>> hw/rtl/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::OFFSET_W-1:0]  block_offset;
    logic [bba_pkg::STATUS_W-1:0]  status;
    logic [bba_pkg::BYTES_W-1:0]   bytes_left;

    modport source (output valid, output block_offset, output status,
                    output bytes_left, input ready);
    modport sink   (input valid, input block_offset, input status,
                    input bytes_left, output ready);
endinterface

>>> hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// Allocator state RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH  = 1,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_W)];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Power-of-two region allocator: lowest-address block search, split on
// allocate, merge with buddy on free. Tree state lives in two RAMs.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  req       in    valid/ready     op, request_bytes, free_offset
//  rsp       out   valid/ready     block_offset, status, bytes_left
//  cfg       in    cfg_we          cfg_data (header bytes)
//
//  Allocate: one node RAM read per tree node scanned, from the target level
//  toward the root, then one split step per level down to the target.
//  Free: merged levels are serialised on the single node RAM write port;
//  a rejected free ends at the offset check or at the leaf RAM lookup.
//  After reset a clearing pass writes every node RAM address before req.ready.
//  A result waits in the rsp register; req is taken again once it is staged.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int NUM_LEVELS    = bba_pkg::NUM_LEVELS_DEF,
    parameter int MIN_BLOCK_LOG = bba_pkg::MIN_BLOCK_LOG_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bba_pkg::HDR_W-1:0]   cfg_data,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp
);

    localparam int RL     = MIN_BLOCK_LOG + NUM_LEVELS - 1;
    localparam int LW     = $clog2(NUM_LEVELS);
    localparam int NW     = NUM_LEVELS;
    localparam int KW     = NUM_LEVELS - 1;
    localparam int RCW    = RL + 1;
    localparam int NEED_W = ((RL + 2) > 18) ? (RL + 2) : 18;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ACHK   = 4'd2;
    localparam logic [3:0] S_ARD    = 4'd3;
    localparam logic [3:0] S_AEVAL  = 4'd4;
    localparam logic [3:0] S_SPLIT  = 4'd5;
    localparam logic [3:0] S_ADONE  = 4'd6;
    localparam logic [3:0] S_FCHK   = 4'd7;
    localparam logic [3:0] S_FLD    = 4'd8;
    localparam logic [3:0] S_FMRD   = 4'd9;
    localparam logic [3:0] S_FMEVAL = 4'd10;
    localparam logic [3:0] S_FMW1   = 4'd11;
    localparam logic [3:0] S_FMW2   = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    localparam logic [RCW-1:0] REGION = RCW'(1) << RL;

    // Heap index of node k at level l
    function automatic logic [NW-1:0] nidx(input logic [LW-1:0] l,
                                           input logic [KW-1:0] k);
        logic [NW-1:0] base;
        base = (NW'(1) << l) - NW'(1);
        return base + NW'(k);
    endfunction

    // Block size at level l
    function automatic logic [RCW-1:0] lsize(input logic [LW-1:0] l);
        return RCW'(1) << (RL - int'(l));
    endfunction

    logic [3:0]                     state_reg, state_next;
    logic [NW-1:0]                  clr_reg, clr_next;
    logic [bba_pkg::HDR_W-1:0]      hdr_reg;
    logic [RCW-1:0]                 rem_reg, rem_next;
    logic [LW-1:0]                  lvl_reg, lvl_next;
    logic [LW-1:0]                  tgt_reg, tgt_next;
    logic [KW-1:0]                  k_reg, k_next;
    logic [bba_pkg::REQ_W-1:0]      req_reg;
    logic [bba_pkg::OFFSET_W-1:0]   off_reg;
    logic [bba_pkg::OFFSET_W-1:0]   res_off_reg, res_off_next;
    logic [bba_pkg::STATUS_W-1:0]   res_st_reg, res_st_next;
    logic                           out_valid_reg;
    logic [bba_pkg::OFFSET_W-1:0]   out_off_reg;
    logic [bba_pkg::STATUS_W-1:0]   out_st_reg;
    logic [bba_pkg::BYTES_W-1:0]    out_left_reg;

    logic                 node_we;
    logic [NW-1:0]        node_waddr;
    logic                 node_wdata;
    logic [NW-1:0]        node_raddr;
    logic                 node_rdata;
    logic                 leaf_we;
    logic [KW-1:0]        leaf_waddr;
    logic [LW:0]          leaf_wdata;
    logic [KW-1:0]        leaf_raddr;
    logic [LW:0]          leaf_rdata;

    logic [NEED_W-1:0]    need;
    logic [LW-1:0]        target;
    logic [KW-1:0]        k_last;
    logic [LW-1:0]        free_lvl;
    logic [KW-1:0]        free_k;
    logic [KW-1:0]        free_leaf;
    logic [KW-1:0]        alloc_leaf;
    logic                 free_bad;
    logic                 out_load;
    logic [NEED_W-1:0]    rem_ext;

    bba_ram #(.WIDTH(1), .ADDR_W(NW)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    bba_ram #(.WIDTH(LW + 1), .ADDR_W(KW)) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    // Size request and pick the deepest level that still holds it
    always_comb
    begin
        int cnt;
        cnt    = 0;
        need   = NEED_W'(req_reg) + NEED_W'(hdr_reg);
        for (int t = 1; t < NUM_LEVELS; t++)
        begin
            if (NEED_W'(lsize(LW'(t))) >= need)
            begin
                cnt = cnt + 1;
            end
        end
        target = LW'(cnt);
    end

    // Decode free offset and stored level
    assign free_leaf  = KW'(off_reg >> MIN_BLOCK_LOG);
    assign free_bad   = (off_reg[MIN_BLOCK_LOG-1:0] != '0)
                        || (NEED_W'(off_reg) >= NEED_W'(REGION));
    assign free_lvl   = (int'(leaf_rdata[LW-1:0]) >= NUM_LEVELS)
                        ? LW'(NUM_LEVELS - 1) : leaf_rdata[LW-1:0];
    assign free_k     = free_leaf >> (NUM_LEVELS - 1 - int'(free_lvl));
    assign alloc_leaf = k_reg << (NUM_LEVELS - 1 - int'(tgt_reg));
    assign k_last     = (KW'(1) << lvl_reg) - KW'(1);
    assign leaf_raddr = free_leaf;
    assign node_raddr = nidx(lvl_reg, (state_reg == S_FMRD) ? (k_reg ^ KW'(1)) : k_reg);
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);
    assign rem_ext    = NEED_W'(rem_reg);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        rem_next     = rem_reg;
        lvl_next     = lvl_reg;
        tgt_next     = tgt_reg;
        k_next       = k_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;
        node_we      = 1'b0;
        node_waddr   = nidx(lvl_reg, k_reg);
        node_wdata   = 1'b0;
        leaf_we      = 1'b0;
        leaf_waddr   = alloc_leaf;
        leaf_wdata   = {1'b1, tgt_reg};
        case (state_reg)
            S_CLEAR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = (clr_reg == '0);
                leaf_we    = 1'b1;
                leaf_waddr = clr_reg[KW-1:0];
                leaf_wdata = '0;
                clr_next   = clr_reg + NW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                res_off_next = '0;
                if (req.valid)
                begin
                    state_next = (req.op == bba_pkg::OP_FREE) ? S_FCHK : S_ACHK;
                end
            end
            S_ACHK:
            begin
                if (need > rem_ext || need > NEED_W'(REGION))
                begin
                    res_st_next = bba_pkg::STATUS_NO_SPACE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    tgt_next   = target;
                    lvl_next   = target;
                    k_next     = '0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                state_next = S_AEVAL;
            end
            S_AEVAL:
            begin
                if (node_rdata)
                begin
                    node_we    = 1'b1;
                    state_next = S_SPLIT;
                end
                else if (k_reg == k_last)
                begin
                    if (lvl_reg == '0)
                    begin
                        res_st_next = bba_pkg::STATUS_NO_SPACE;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg - LW'(1);
                        k_next     = '0;
                        state_next = S_ARD;
                    end
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_ARD;
                end
            end
            S_SPLIT:
            begin
                // Leave the upper half free one level down
                if (lvl_reg == tgt_reg)
                begin
                    state_next = S_ADONE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LW'(1);
                    k_next     = k_reg << 1;
                    node_we    = 1'b1;
                    node_waddr = nidx(lvl_reg + LW'(1), (k_reg << 1) | KW'(1));
                    node_wdata = 1'b1;
                end
            end
            S_ADONE:
            begin
                leaf_we      = 1'b1;
                rem_next     = rem_reg - lsize(tgt_reg);
                res_off_next = bba_pkg::OFFSET_W'(NEED_W'(alloc_leaf) << MIN_BLOCK_LOG);
                res_st_next  = bba_pkg::STATUS_OK;
                state_next   = S_EMIT;
            end
            S_FCHK:
            begin
                if (free_bad)
                begin
                    res_st_next = bba_pkg::STATUS_INVALID;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_FLD;
                end
            end
            S_FLD:
            begin
                if (!leaf_rdata[LW])
                begin
                    res_st_next = bba_pkg::STATUS_INVALID;
                    state_next  = S_EMIT;
                end
                else
                begin
                    leaf_we    = 1'b1;
                    leaf_waddr = free_leaf;
                    leaf_wdata = {1'b0, leaf_rdata[LW-1:0]};
                    rem_next   = rem_reg + lsize(free_lvl);
                    lvl_next   = free_lvl;
                    k_next     = free_k;
                    node_we    = 1'b1;
                    node_waddr = nidx(free_lvl, free_k);
                    node_wdata = 1'b1;
                    state_next = S_FMRD;
                end
            end
            S_FMRD:
            begin
                if (lvl_reg == '0)
                begin
                    res_st_next = bba_pkg::STATUS_OK;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_FMEVAL;
                end
            end
            S_FMEVAL:
            begin
                if (node_rdata)
                begin
                    node_we    = 1'b1;
                    node_waddr = nidx(lvl_reg, k_reg ^ KW'(1));
                    state_next = S_FMW1;
                end
                else
                begin
                    res_st_next = bba_pkg::STATUS_OK;
                    state_next  = S_EMIT;
                end
            end
            S_FMW1:
            begin
                node_we    = 1'b1;
                state_next = S_FMW2;
            end
            S_FMW2:
            begin
                // Mark the merged parent free and climb
                lvl_next   = lvl_reg - LW'(1);
                k_next     = k_reg >> 1;
                node_we    = 1'b1;
                node_waddr = nidx(lvl_reg - LW'(1), k_reg >> 1);
                node_wdata = 1'b1;
                state_next = S_FMRD;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            hdr_reg       <= bba_pkg::HEADER_RESET;
            rem_reg       <= REGION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rem_reg   <= rem_next;
            if (cfg_we)
            begin
                hdr_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        lvl_reg     <= lvl_next;
        tgt_reg     <= tgt_next;
        k_reg       <= k_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        if (req.valid && req.ready)
        begin
            req_reg <= req.request_bytes;
            off_reg <= req.free_offset;
        end
        if (out_load)
        begin
            out_off_reg  <= res_off_reg;
            out_st_reg   <= res_st_reg;
            out_left_reg <= rem_ext[bba_pkg::BYTES_W-1:0];
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.block_offset = out_off_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.bytes_left   = out_left_reg;

endmodule

>>> hw/rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Response channel checks, bound to the allocator top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bba_pkg::OFFSET_W-1:0]  block_offset,
    input logic [bba_pkg::STATUS_W-1:0]  status,
    input logic [bba_pkg::BYTES_W-1:0]   bytes_left
);

    // Hold a stalled beat
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(block_offset) && $stable(status)
                                    && $stable(bytes_left))
        else $error("rsp payload changed while stalled");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == bba_pkg::STATUS_OK)
                      || (status == bba_pkg::STATUS_NO_SPACE)
                      || (status == bba_pkg::STATUS_INVALID))
        else $error("undefined status code");

    // Failed requests report offset zero
    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != bba_pkg::STATUS_OK) |-> block_offset == '0)
        else $error("nonzero offset on failure");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .block_offset (rsp.block_offset),
    .status       (rsp.status),
    .bytes_left   (rsp.bytes_left)
);
